>>> rtl/core/ffba_pkg.sv
// Shared constants, types, conversions and the sequencer control store of the allocator.
`default_nettype none

package ffba_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int ADDRESS_BITS  = 20;

    // Fixed widths of the port fields
    localparam int AMOUNT_W   = 21;
    localparam int PORT_ADR_W = 20;
    localparam int POOL_W     = 21;
    localparam logic [POOL_W-1:0] POOL_RESET = 21'd1048576;

    localparam int LEN_W = ADDRESS_BITS + 1;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CMP_W = (LEN_W > AMOUNT_W) ? LEN_W : AMOUNT_W;
    localparam int XA_W  = (ADDRESS_BITS > PORT_ADR_W) ? ADDRESS_BITS : PORT_ADR_W;

    typedef logic [ADDRESS_BITS-1:0] addr_t;
    typedef logic [LEN_W-1:0]        len_t;
    typedef logic [IDX_W-1:0]        idx_t;

    localparam idx_t LAST_IDX = idx_t'(TABLE_ENTRIES - 1);

    // Sequencer steps
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] S_IDLE      = 4'd0;
    localparam logic [STEP_W-1:0] S_DISPATCH  = 4'd1;
    localparam logic [STEP_W-1:0] S_CHECK     = 4'd2;
    localparam logic [STEP_W-1:0] S_FIT       = 4'd3;
    localparam logic [STEP_W-1:0] S_REST      = 4'd4;
    localparam logic [STEP_W-1:0] S_SPARE     = 4'd5;
    localparam logic [STEP_W-1:0] S_COMMIT    = 4'd6;
    localparam logic [STEP_W-1:0] S_FAIL      = 4'd7;
    localparam logic [STEP_W-1:0] S_FREE      = 4'd8;
    localparam logic [STEP_W-1:0] S_FREE_DONE = 4'd9;

    // Jump conditions
    localparam logic [2:0] C_ALWAYS = 3'd0;
    localparam logic [2:0] C_START  = 3'd1;
    localparam logic [2:0] C_FREE   = 3'd2;
    localparam logic [2:0] C_ZERO   = 3'd3;
    localparam logic [2:0] C_FITS   = 3'd4;
    localparam logic [2:0] C_EXACT  = 3'd5;
    localparam logic [2:0] C_EMPTY  = 3'd6;
    localparam logic [2:0] C_NEVER  = 3'd7;

    // Datapath operations
    localparam logic [2:0] OP_NONE        = 3'd0;
    localparam logic [2:0] OP_LATCH_FIT   = 3'd1;
    localparam logic [2:0] OP_LATCH_SPARE = 3'd2;
    localparam logic [2:0] OP_CLEAR       = 3'd3;
    localparam logic [2:0] OP_COMMIT      = 3'd4;
    localparam logic [2:0] OP_FAIL        = 3'd5;
    localparam logic [2:0] OP_FREED       = 3'd6;

    typedef struct packed {
        logic              scan;     // walk the table index until the condition hits
        logic [2:0]        cond;
        logic [STEP_W-1:0] tgt_true;
        logic [STEP_W-1:0] tgt_end;
        logic [2:0]        op;
        logic              idx_clr;
    } uc_word_t;

    function automatic uc_word_t uc_rom(input logic [STEP_W-1:0] step);
        uc_word_t w;
        w = '{scan: 1'b0, cond: C_ALWAYS, tgt_true: S_IDLE, tgt_end: S_IDLE,
              op: OP_NONE, idx_clr: 1'b0};
        case (step)
            S_IDLE:      w = '{1'b0, C_START, S_DISPATCH, S_IDLE,      OP_NONE,        1'b1};
            S_DISPATCH:  w = '{1'b0, C_FREE,  S_FREE,     S_CHECK,     OP_NONE,        1'b0};
            S_CHECK:     w = '{1'b0, C_ZERO,  S_FAIL,     S_FIT,       OP_NONE,        1'b0};
            S_FIT:       w = '{1'b1, C_FITS,  S_REST,     S_FAIL,      OP_LATCH_FIT,   1'b0};
            S_REST:      w = '{1'b0, C_EXACT, S_COMMIT,   S_SPARE,     OP_NONE,        1'b1};
            S_SPARE:     w = '{1'b1, C_EMPTY, S_COMMIT,   S_FAIL,      OP_LATCH_SPARE, 1'b0};
            S_COMMIT:    w = '{1'b0, C_ALWAYS, S_IDLE,    S_IDLE,      OP_COMMIT,      1'b0};
            S_FAIL:      w = '{1'b0, C_ALWAYS, S_IDLE,    S_IDLE,      OP_FAIL,        1'b0};
            S_FREE:      w = '{1'b1, C_NEVER, S_IDLE,     S_FREE_DONE, OP_CLEAR,       1'b0};
            S_FREE_DONE: w = '{1'b0, C_ALWAYS, S_IDLE,    S_IDLE,      OP_FREED,       1'b0};
            default:     w = '{1'b0, C_ALWAYS, S_IDLE,    S_IDLE,      OP_NONE,        1'b1};
        endcase
        return w;
    endfunction

    function automatic addr_t port_to_addr(input logic [PORT_ADR_W-1:0] a);
        logic [XA_W-1:0] w;
        w = XA_W'(a);
        return w[ADDRESS_BITS-1:0];
    endfunction

    function automatic logic [PORT_ADR_W-1:0] addr_to_port(input addr_t a);
        logic [XA_W-1:0] w;
        w = XA_W'(a);
        return w[PORT_ADR_W-1:0];
    endfunction

    function automatic logic [CMP_W-1:0] amount_wide(input logic [AMOUNT_W-1:0] a);
        return CMP_W'(a);
    endfunction

    function automatic len_t amount_to_len(input logic [AMOUNT_W-1:0] a);
        logic [CMP_W-1:0] w;
        w = CMP_W'(a);
        return w[LEN_W-1:0];
    endfunction

    function automatic addr_t amount_to_addr(input logic [AMOUNT_W-1:0] a);
        logic [CMP_W+ADDRESS_BITS-1:0] w;
        w = (CMP_W+ADDRESS_BITS)'(a);
        return w[ADDRESS_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/first_fit_block_allocator_unit.sv
// Top level of the first-fit block allocator: control store sequencer and descriptor table.
//
// Usage:
//   Requests enter on start/busy: an item is taken at a clock edge with start high and
//   busy low. mode 0 allocates amount bytes, mode 1 frees the block at start_address.
//   Each item gives one result on ok/address, shown for exactly one cycle with done high;
//   the receiver cannot stall, so the result must be taken in that cycle.
//   The pool size is written from cfg_data on cfg_valid/cfg_ready (ready while not busy) and rebuilds the
//   table at once: entry 0 covers the pool, the other entries are empty.
// Sequence, from the accepting edge to the edge that ends the done cycle:
//   free: dispatch, sixteen-entry sweep, finish, result.
//   allocate: a zero amount fails after the dispatch and the check; otherwise the fit scan and
//   the empty-slot scan may both walk all sixteen entries. One table entry is examined per
//   cycle through a single read index; the control store steps once per cycle.
//   A new item may be taken in the same cycle that done is shown.
// Reset: asynchronous, active low; the table returns to a 1048576-byte pool in entry 0,
//   the sequencer goes idle, and no result is pending.
`default_nettype none

module first_fit_block_allocator_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic                             mode,
    input  wire logic [ffba_pkg::AMOUNT_W-1:0]    amount,
    input  wire logic [ffba_pkg::PORT_ADR_W-1:0]  start_address,
    output logic                                  done,
    output logic                                  ok,
    output logic [ffba_pkg::PORT_ADR_W-1:0]       address,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [ffba_pkg::POOL_W-1:0]      cfg_data
);
    import ffba_pkg::*;

    addr_t entry_start_reg  [TABLE_ENTRIES];
    len_t  entry_length_reg [TABLE_ENTRIES];
    logic  entry_used_reg   [TABLE_ENTRIES];

    logic [STEP_W-1:0] step_reg, step_next;
    idx_t              idx_reg, idx_next;
    logic              done_reg, done_next;

    logic                  mode_reg;
    logic [AMOUNT_W-1:0]   amount_reg;
    logic [PORT_ADR_W-1:0] free_addr_reg;
    idx_t                  fit_idx_reg;
    addr_t                 fit_start_reg;
    len_t                  rest_reg;
    idx_t                  spare_idx_reg;
    logic                  split_reg;
    logic                  ok_reg;
    logic [PORT_ADR_W-1:0] address_reg;

    uc_word_t uw;
    logic     accept;
    logic     cfg_write;
    logic     cond_hit;
    addr_t    cur_start;
    len_t     cur_len;
    logic     cur_used;
    logic [CMP_W-1:0] rest_wide;

    assign busy      = (step_reg != S_IDLE);
    assign cfg_ready = ~busy;
    assign accept    = start & ~busy;
    assign cfg_write = cfg_valid & cfg_ready;
    assign done      = done_reg;
    assign ok        = ok_reg;
    assign address   = address_reg;

    assign uw        = uc_rom(step_reg);
    assign cur_start = entry_start_reg[idx_reg];
    assign cur_len   = entry_length_reg[idx_reg];
    assign cur_used  = entry_used_reg[idx_reg];
    assign rest_wide = CMP_W'(cur_len) - amount_wide(amount_reg);

    always_comb
    begin
        case (uw.cond)
            C_ALWAYS: cond_hit = 1'b1;
            C_START:  cond_hit = start;
            C_FREE:   cond_hit = mode_reg;
            C_ZERO:   cond_hit = (amount_reg == '0);
            C_FITS:   cond_hit = ~cur_used && (cur_len != '0)
                                 && (CMP_W'(cur_len) >= amount_wide(amount_reg));
            C_EXACT:  cond_hit = (rest_reg == '0);
            C_EMPTY:  cond_hit = (cur_len == '0);
            C_NEVER:  cond_hit = 1'b0;
            default:  cond_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        idx_next  = idx_reg;
        if (cond_hit)
        begin
            step_next = uw.tgt_true;
        end
        else if (uw.scan && (idx_reg != LAST_IDX))
        begin
            idx_next = idx_reg + idx_t'(1);
        end
        else
        begin
            step_next = uw.tgt_end;
        end
        if (uw.idx_clr)
        begin
            idx_next = '0;
        end
        done_next = (uw.op == OP_COMMIT) || (uw.op == OP_FAIL) || (uw.op == OP_FREED);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_IDLE;
            idx_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            idx_reg  <= idx_next;
            done_reg <= done_next;
        end
    end

    // Request latch, scan results and the result register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg      <= mode;
            amount_reg    <= amount;
            free_addr_reg <= start_address;
            split_reg     <= 1'b0;
        end
        case (uw.op)
            OP_LATCH_FIT:
            begin
                if (cond_hit)
                begin
                    fit_idx_reg   <= idx_reg;
                    fit_start_reg <= cur_start;
                    rest_reg      <= rest_wide[LEN_W-1:0];
                end
            end
            OP_LATCH_SPARE:
            begin
                if (cond_hit)
                begin
                    spare_idx_reg <= idx_reg;
                    split_reg     <= 1'b1;
                end
            end
            OP_COMMIT:
            begin
                ok_reg      <= 1'b1;
                address_reg <= addr_to_port(fit_start_reg);
            end
            OP_FAIL:
            begin
                ok_reg      <= 1'b0;
                address_reg <= '0;
            end
            OP_FREED:
            begin
                ok_reg      <= 1'b1;
                address_reg <= addr_to_port(port_to_addr(free_addr_reg));
            end
            default:
            begin
            end
        endcase
    end

    // Descriptor table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                entry_start_reg[i]  <= '0;
                entry_length_reg[i] <= '0;
                entry_used_reg[i]   <= 1'b0;
            end
            entry_length_reg[0] <= amount_to_len(POOL_RESET);
        end
        else if (cfg_write)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                entry_start_reg[i]  <= '0;
                entry_length_reg[i] <= '0;
                entry_used_reg[i]   <= 1'b0;
            end
            entry_length_reg[0] <= amount_to_len(cfg_data);
        end
        else
        begin
            case (uw.op)
                OP_CLEAR:
                begin
                    if ((cur_len != '0) && (cur_start == port_to_addr(free_addr_reg)))
                    begin
                        entry_used_reg[idx_reg] <= 1'b0;
                    end
                end
                OP_COMMIT:
                begin
                    // hand the remainder to the empty slot, then shrink the fit
                    if (split_reg)
                    begin
                        entry_start_reg[spare_idx_reg]  <= fit_start_reg
                                                           + amount_to_addr(amount_reg);
                        entry_length_reg[spare_idx_reg] <= rest_reg;
                        entry_used_reg[spare_idx_reg]   <= 1'b0;
                    end
                    entry_length_reg[fit_idx_reg] <= amount_to_len(amount_reg);
                    entry_used_reg[fit_idx_reg]   <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/ffba_checker.sv
// Port-level checks on the allocator, bound to the top level.
`default_nettype none

module ffba_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              start,
    input wire logic                              busy,
    input wire logic                              done,
    input wire logic                              ok,
    input wire logic [ffba_pkg::PORT_ADR_W-1:0]   address
);
    import ffba_pkg::*;

    // A result only appears once the sequencer is back at rest
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item taken but block not busy");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !ok) |-> (address == '0))
        else $error("failed request with non-zero address");

    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

endmodule

bind first_fit_block_allocator_unit ffba_checker u_ffba_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .ok      (ok),
    .address (address)
);

`default_nettype wire
